@@ rtl/mcpwm_pkg.sv @@
// Shared types and constants of the multi-channel PWM table.
// Holds the command codes, the period reset value and the channel entry layout.
// Depends on nothing.
`timescale 1ns / 1ps

package mcpwm_pkg;

  localparam int PORT_W = 4;
  localparam int PIN_W  = 5;
  localparam int DUTY_W = 16;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [DUTY_W-1:0] PERIOD_RESET = 16'd10;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [PIN_W-1:0]  pin;
    logic [DUTY_W-1:0] duty;
  } chan_entry_t;

  localparam int ENTRY_W = $bits(chan_entry_t);

endpackage

@@ rtl/mcpwm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used by the PWM table core for its channel store.
`timescale 1ns / 1ps

module mcpwm_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/multi_channel_pwm_table_core.sv @@
// Multi-channel PWM table core: an ordered channel table held in one synchronous RAM.
// Set and remove search the table entry by entry; remove then moves each later entry one
// place towards the head. A tick scans every entry once, or twice on a wrap (high, then low).
// Each RAM visit is a read state followed by a check state.
// One transaction is worked at a time; a finished result may wait while the next is taken.
// Synchronous reset empties the table, clears the counter and loads a period of 10.
`timescale 1ns / 1ps

module multi_channel_pwm_table_core #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel: the PWM period.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] period,
  // Command channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [3:0]  port_id,
  input  logic [4:0]  pin_number,
  input  logic [15:0] duty,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        event_valid,
  output logic [3:0]  out_port,
  output logic [4:0]  out_pin,
  output logic        out_level,
  output logic        found,
  output logic        table_full,
  output logic        last_result
);

  // Index into the table and a count that can also hold the full depth.
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int CW1   = CNT_W + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SHR  = 3'd3;
  localparam logic [2:0] S_SHW  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state;
  logic [1:0]       cmd;
  logic [3:0]       key_port;
  logic [4:0]       key_pin;
  logic [15:0]      key_duty;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic [15:0]      tick_counter;
  logic [15:0]      tick_period;
  logic             phase_low;
  logic             r_found;
  logic             r_full;

  // One-deep holding register for the latest pin event. An event can only be marked as the
  // last of its tick once the scan has ended, so each event waits here until the next one
  // arrives or the scan completes.
  logic             p_valid;
  logic [3:0]       p_port;
  logic [4:0]       p_pin;
  logic             p_level;

  // RAM interface.
  logic                         ram_we;
  logic                         ram_re;
  logic [IDX_W-1:0]             ram_waddr;
  logic [IDX_W-1:0]             ram_raddr;
  mcpwm_pkg::chan_entry_t       ram_wdata;
  logic [mcpwm_pkg::ENTRY_W-1:0] ram_rdata;
  mcpwm_pkg::chan_entry_t       rd_entry;

  logic        out_free;
  logic        out_load;
  logic        key_match;
  logic        at_last;
  logic        tick_hit;
  logic        has_room;
  logic [16:0] tick_inc;
  logic        wrap;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign rd_entry  = mcpwm_pkg::chan_entry_t'(ram_rdata);
  assign key_match = (rd_entry.port == key_port) && (rd_entry.pin == key_pin);
  assign at_last   = ((CNT_W'(idx) + CNT_W'(1)) == count);
  // In the first pass of a wrapping tick every channel goes high; in the second pass only
  // those whose duty equals the counter go low.
  assign tick_hit  = !phase_low || (rd_entry.duty == tick_counter);
  assign has_room  = (count < CNT_W'(MAX_CHANNELS));
  assign tick_inc  = {1'b0, tick_counter} + 17'd1;
  assign wrap      = (tick_inc >= {1'b0, tick_period});

  // The result register takes a new transaction when a held pin event is passed on during
  // the scan, or when the command finishes, and only while the register is free.
  assign out_load  = ((state == S_CHK) && (cmd == mcpwm_pkg::CMD_TICK) && tick_hit &&
                      p_valid && out_free) || ((state == S_DONE) && out_free);

  // RAM address and write control.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx;
    ram_raddr = idx;
    ram_wdata = '{port: key_port, pin: key_pin, duty: key_duty};
    unique case (state)
      S_IDLE: begin
        // A set on an empty table appends straight away at entry zero.
        if (in_valid && (command == mcpwm_pkg::CMD_SET) && (count == '0)) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = '{port: port_id, pin: pin_number, duty: duty};
        end
      end
      S_RD: begin
        ram_re = 1'b1;
      end
      S_CHK: begin
        if (cmd == mcpwm_pkg::CMD_SET) begin
          if (key_match) begin
            ram_we = 1'b1;
          end else if (at_last && has_room) begin
            ram_we    = 1'b1;
            ram_waddr = count[IDX_W-1:0];
          end
        end
      end
      S_SHR: begin
        ram_re    = 1'b1;
        ram_raddr = idx + IDX_W'(1);
      end
      S_SHW: begin
        // Close the gap: the entry above moves down one place.
        ram_we    = 1'b1;
        ram_wdata = rd_entry;
      end
      default: begin
      end
    endcase
  end

  mcpwm_ram #(
    .WIDTH(mcpwm_pkg::ENTRY_W),
    .DEPTH(MAX_CHANNELS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer, counter, period register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      tick_counter <= '0;
      tick_period  <= mcpwm_pkg::PERIOD_RESET;
      out_valid    <= 1'b0;
      p_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tick_period <= period;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd       <= command;
            key_port  <= port_id;
            key_pin   <= pin_number;
            key_duty  <= duty;
            idx       <= '0;
            r_found   <= 1'b0;
            r_full    <= 1'b0;
            phase_low <= !wrap;
            unique case (command)
              mcpwm_pkg::CMD_TICK: begin
                tick_counter <= wrap ? 16'd0 : tick_inc[15:0];
                state        <= (count != '0) ? S_RD : S_DONE;
              end
              mcpwm_pkg::CMD_SET: begin
                if (count == '0) begin
                  count <= CNT_W'(1);
                  state <= S_DONE;
                end else begin
                  state <= S_RD;
                end
              end
              mcpwm_pkg::CMD_REMOVE: begin
                state <= (count != '0) ? S_RD : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        S_RD: begin
          state <= S_CHK;
        end

        S_CHK: begin
          if (cmd == mcpwm_pkg::CMD_TICK) begin
            // Hold on this entry while a held event cannot be passed on.
            if (!(tick_hit && p_valid && !out_free)) begin
              if (tick_hit) begin
                if (p_valid) begin
                  event_valid <= 1'b1;
                  out_port    <= p_port;
                  out_pin     <= p_pin;
                  out_level   <= p_level;
                  found       <= 1'b0;
                  table_full  <= 1'b0;
                  last_result <= 1'b0;
                end
                p_valid <= 1'b1;
                p_port  <= rd_entry.port;
                p_pin   <= rd_entry.pin;
                p_level <= !phase_low;
              end
              if (at_last) begin
                if (!phase_low) begin
                  phase_low <= 1'b1;
                  idx       <= '0;
                  state     <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end else begin
                idx   <= idx + IDX_W'(1);
                state <= S_RD;
              end
            end
          end else if (key_match) begin
            r_found <= 1'b1;
            if (cmd == mcpwm_pkg::CMD_SET) begin
              state <= S_DONE;
            end else if (at_last) begin
              count <= count - CNT_W'(1);
              state <= S_DONE;
            end else begin
              state <= S_SHR;
            end
          end else if (at_last) begin
            if (cmd == mcpwm_pkg::CMD_SET) begin
              if (has_room) begin
                count <= count + CNT_W'(1);
              end else begin
                r_full <= 1'b1;
              end
            end
            state <= S_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_RD;
          end
        end

        S_SHR: begin
          state <= S_SHW;
        end

        S_SHW: begin
          if ((CW1'(idx) + CW1'(2)) == CW1'(count)) begin
            count <= count - CNT_W'(1);
            state <= S_DONE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SHR;
          end
        end

        S_DONE: begin
          if (out_free) begin
            last_result <= 1'b1;
            if ((cmd == mcpwm_pkg::CMD_TICK) && p_valid) begin
              event_valid <= 1'b1;
              out_port    <= p_port;
              out_pin     <= p_pin;
              out_level   <= p_level;
              found       <= 1'b0;
              table_full  <= 1'b0;
              p_valid     <= 1'b0;
            end else begin
              event_valid <= 1'b0;
              out_port    <= '0;
              out_pin     <= '0;
              out_level   <= 1'b0;
              found       <= r_found;
              table_full  <= r_full;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table never holds more channels than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CHANNELS))
    else $error("channel count beyond table depth");

  // A command adds or removes at most one channel.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ((count == $past(count) + CNT_W'(1)) || (count == $past(count) - CNT_W'(1))))
    else $error("channel count moved by more than one");

  // An entry is only checked while it lies within the valid part of the table.
  a_idx_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (CNT_W'(idx) < count))
    else $error("table entry checked beyond channel count");

  // A held pin event never outlives its tick.
  a_pend_busy: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> ((state != S_IDLE) && (cmd == mcpwm_pkg::CMD_TICK)))
    else $error("pin event held outside a tick");

  // Pin events never carry set or remove status.
  a_event_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_valid) |-> (!found && !table_full))
    else $error("pin event carries command status");

endmodule

@@ bench/multi_channel_pwm_table_core_test.sv @@
// Self-checking bench for multi_channel_pwm_table_core: a directed table, then random traffic.
// Depends on rtl/mcpwm_pkg.sv, rtl/mcpwm_ram.sv and rtl/multi_channel_pwm_table_core.sv.
`timescale 1ns / 1ps

module multi_channel_pwm_table_core_test;

  localparam int MAX_CH        = 16;
  // Long enough for a full two-pass tick over sixteen entries, with a margin.
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 150;
  localparam int PLAN_ROWS     = 19;

  // One result transaction, field by field.
  typedef struct packed {
    logic                         ev;
    logic [mcpwm_pkg::PORT_W-1:0] port;
    logic [mcpwm_pkg::PIN_W-1:0]  pin;
    logic                         level;
    logic                         found;
    logic                         full;
    logic                         last;
  } pin_result_t;

  // A plan row either sends a command or rewrites the period. Rows whose outcome is
  // obvious carry it by name; the rest are worked out by the table model below.
  typedef enum logic {ROW_CMD, ROW_PERIOD} row_kind_t;
  typedef enum logic [1:0] {OUT_MODEL, OUT_QUIET, OUT_FOUND, OUT_FULL} row_out_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  cmd;
    logic [3:0]  port;
    logic [4:0]  pin;
    logic [15:0] value;
    row_out_t    out;
  } plan_row_t;

  // Directed part. The period starts at 10 after reset and the counter at 0.
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_CMD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_QUIET},  // empty table, no events
    '{ROW_CMD, mcpwm_pkg::CMD_REMOVE, 4'd15, 5'd31, 16'hFFFF, OUT_QUIET},  // nothing to remove
    '{ROW_CMD, mcpwm_pkg::CMD_NONE, 4'd15, 5'd31, 16'hFFFF, OUT_QUIET},  // unused code ignored
    '{ROW_CMD, mcpwm_pkg::CMD_SET, 4'd0, 5'd0, 16'd0, OUT_QUIET},  // append
    '{ROW_CMD, mcpwm_pkg::CMD_SET, 4'd15, 5'd31, 16'hFFFF, OUT_QUIET},  // append, never low
    '{ROW_CMD, mcpwm_pkg::CMD_SET, 4'd0, 5'd0, 16'd1, OUT_FOUND},  // update in place
    '{ROW_CMD, mcpwm_pkg::CMD_SET, 4'd10, 5'd21, 16'd2, OUT_QUIET},
    '{ROW_CMD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_MODEL},  // counter 2, one low
    '{ROW_CMD, mcpwm_pkg::CMD_REMOVE, 4'd0, 5'd0, 16'd0, OUT_FOUND},  // head removed
    '{ROW_CMD, mcpwm_pkg::CMD_SET, 4'd0, 5'd0, 16'd0, OUT_QUIET},  // re-added at the tail
    '{ROW_PERIOD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd3, OUT_MODEL},
    // Wrap: the duty-zero channel goes high and then low.
    '{ROW_CMD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_MODEL},
    '{ROW_PERIOD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_MODEL},
    '{ROW_CMD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_MODEL},  // zero period always wraps
    '{ROW_PERIOD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'hFFFF, OUT_MODEL},
    '{ROW_CMD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_MODEL},
    '{ROW_CMD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_MODEL},
    '{ROW_PERIOD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd1, OUT_MODEL},  // now below counter
    '{ROW_CMD, mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_MODEL}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] period;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [3:0]  port_id;
  logic [4:0]  pin_number;
  logic [15:0] duty;
  logic        out_valid;
  logic        out_stall;
  logic        event_valid;
  logic [3:0]  out_port;
  logic [4:0]  out_pin;
  logic        out_level;
  logic        found;
  logic        table_full;
  logic        last_result;

  multi_channel_pwm_table_core #(.MAX_CHANNELS(MAX_CH)) dut (.*);

  always #10 clk = ~clk;

  // Our own copy of the block's state, advanced once per accepted command transaction.
  logic [15:0]            pwm_period;
  logic [15:0]            pwm_counter;
  mcpwm_pkg::chan_entry_t chans [MAX_CH];
  int                     chan_count;

  // Pin events still owed by the block, oldest first, and those of the latest command.
  pin_result_t pending_results [$];
  pin_result_t step_results [$];

  int result_errors = 0;
  int quiet_cycles  = 0;
  int hold_requests = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  function automatic pin_result_t make_result(logic ev, logic [3:0] p, logic [4:0] n,
                                              logic lvl, logic fnd, logic full,
                                              logic last);
    pin_result_t r;
    r.ev    = ev;
    r.port  = p;
    r.pin   = n;
    r.level = lvl;
    r.found = fnd;
    r.full  = full;
    r.last  = last;
    return r;
  endfunction

  function automatic int find_chan(logic [3:0] p, logic [4:0] n);
    for (int i = 0; i < chan_count; i++)
      if (chans[i].port == p && chans[i].pin == n) return i;
    return -1;
  endfunction

  // Applies one command to the table copy and lists the pin events it causes.
  task automatic apply_command(input logic [1:0] cmd, input logic [3:0] p,
                               input logic [4:0] n, input logic [15:0] d);
    int          slot;
    logic [16:0] next_count;
    pin_result_t tail;
    step_results.delete();
    slot = find_chan(p, n);
    case (cmd)
      mcpwm_pkg::CMD_SET: begin
        if (slot >= 0) begin
          chans[slot].duty = d;
          step_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0, 1'b1, 1'b0, 1'b1));
        end else if (chan_count >= MAX_CH) begin
          step_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0, 1'b0, 1'b1, 1'b1));
        end else begin
          chans[chan_count].port = p;
          chans[chan_count].pin  = n;
          chans[chan_count].duty = d;
          chan_count++;
          step_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        end
      end
      mcpwm_pkg::CMD_REMOVE: begin
        if (slot >= 0) begin
          // Close the gap so that the remaining channels keep their order.
          for (int i = slot; i < chan_count - 1; i++) chans[i] = chans[i + 1];
          chan_count--;
          step_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0, 1'b1, 1'b0, 1'b1));
        end else begin
          step_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        end
      end
      mcpwm_pkg::CMD_TICK: begin
        next_count = {1'b0, pwm_counter} + 17'd1;
        if (next_count >= {1'b0, pwm_period}) begin
          // Wrap: every channel goes high, in table order.
          pwm_counter = '0;
          for (int i = 0; i < chan_count; i++)
            step_results.push_back(make_result(1'b1, chans[i].port, chans[i].pin,
                                               1'b1, 1'b0, 1'b0, 1'b0));
        end else begin
          pwm_counter = next_count[15:0];
        end
        for (int i = 0; i < chan_count; i++)
          if (chans[i].duty == pwm_counter)
            step_results.push_back(make_result(1'b1, chans[i].port, chans[i].pin,
                                               1'b0, 1'b0, 1'b0, 1'b0));
        if (step_results.size() == 0) begin
          step_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1));
        end else begin
          tail = step_results.pop_back();
          tail.last = 1'b1;
          step_results.push_back(tail);
        end
      end
      default: begin
        step_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic flag_result_error(input string msg);
    result_errors++;
    $display("[%0t] result mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) flag_result_error($sformatf("%s is %0d, should be %0d", name, got, want));
  endtask

  // Offers one command transaction after a random gap and holds it until it is taken.
  // The valid is only lowered when there is a gap, so it never drops and rises in one step.
  task automatic send_command(input logic [1:0] cmd, input logic [3:0] p,
                              input logic [4:0] n, input logic [15:0] d,
                              input row_out_t out);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    port_id    <= p;
    pin_number <= n;
    duty       <= d;
    do @(posedge clk); while (in_stall);
    apply_command(cmd, p, n, d);
    case (out)
      OUT_MODEL: foreach (step_results[i]) pending_results.push_back(step_results[i]);
      OUT_FOUND: pending_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0,
                                                       1'b1, 1'b0, 1'b1));
      OUT_FULL:  pending_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0,
                                                       1'b0, 1'b1, 1'b1));
      default:   pending_results.push_back(make_result(1'b0, 4'd0, 5'd0, 1'b0,
                                                       1'b0, 1'b0, 1'b1));
    endcase
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_results_clear();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // The period is only rewritten with the block idle and the table copy in step.
  task automatic write_period(input logic [15:0] v);
    wait_results_clear();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    period    <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    pwm_period  = v;
  endtask

  // Random command. Keys mostly hit channels already in the table or a small pool, so
  // updates and removals happen often; the rest are drawn over the whole key space.
  // Mode 1 leans towards filling the table, mode 2 towards emptying it.
  task automatic send_random_command(input int mode, inout int sent);
    logic [1:0]  cmd;
    logic [3:0]  p;
    logic [4:0]  n;
    logic [15:0] d;
    int          pick;
    int          slot;
    int          set_bound;
    set_bound = (mode == 1) ? 90 : (mode == 2) ? 60 : 75;
    pick = $urandom_range(0, 99);
    if (pick < 3) cmd = mcpwm_pkg::CMD_NONE;
    else if (pick < 45) cmd = mcpwm_pkg::CMD_TICK;
    else if (pick < set_bound) cmd = mcpwm_pkg::CMD_SET;
    else cmd = mcpwm_pkg::CMD_REMOVE;

    pick = $urandom_range(0, 9);
    if (chan_count > 0 && pick < 5) begin
      slot = $urandom_range(0, chan_count - 1);
      p    = chans[slot].port;
      n    = chans[slot].pin;
    end else if (pick < 8) begin
      slot = $urandom_range(0, 23);
      p    = 4'(slot);
      n    = 5'(slot + 7);
    end else begin
      p = 4'($urandom_range(0, 15));
      n = 5'($urandom_range(0, 31));
    end

    // Duties near the running counter make low events likely whatever the period.
    pick = $urandom_range(0, 4);
    if (pick == 0) d = 16'($urandom_range(0, 65535));
    else if (pick < 3) d = pwm_counter + 16'($urandom_range(0, 5));
    else d = 16'($urandom_range(0, (pwm_period < 16'd20) ? int'(pwm_period) : 20));

    send_command(cmd, p, n, d, OUT_MODEL);
    if (cmd != mcpwm_pkg::CMD_NONE) sent++;
  endtask

  // Result side: a random hold-off after each accepted result, and one long hold-off
  // whenever the stimulus asks for it, counted here so the sender keeps offering.
  initial begin : result_sink
    int gap;
    int holds_served;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      gap = 0;
      if (!rst && out_valid && !out_stall && !rx_calm) gap = $urandom_range(0, 9);
      if (holds_served != hold_requests) begin
        holds_served++;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result is matched against the oldest owed one.
  always @(posedge clk) begin
    pin_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_result_error("result transaction with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("event_valid", 8'(event_valid), 8'(want.ev));
        check_field("out_port",    8'(out_port),    8'(want.port));
        check_field("out_pin",     8'(out_pin),     8'(want.pin));
        check_field("out_level",   8'(out_level),   8'(want.level));
        check_field("found",       8'(found),       8'(want.found));
        check_field("table_full",  8'(table_full),  8'(want.full));
        check_field("last_result", 8'(last_result), 8'(want.last));
      end
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d results owed",
               $time, STALL_LIMIT, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          random_sent;
    int          pick;
    int          mode;
    int          burst;
    int          pause_at;
    bit          hold_done;
    logic [15:0] next_period;

    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    period     <= mcpwm_pkg::PERIOD_RESET;
    in_valid   <= 1'b0;
    command    <= mcpwm_pkg::CMD_TICK;
    port_id    <= '0;
    pin_number <= '0;
    duty       <= '0;
    pwm_period  = mcpwm_pkg::PERIOD_RESET;
    pwm_counter = '0;
    chan_count  = 0;
    random_sent = 0;
    hold_done   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_PERIOD) write_period(plan[r].value);
      else send_command(plan[r].cmd, plan[r].port, plan[r].pin, plan[r].value, plan[r].out);
    end

    // Fill the table with duty-zero channels, try one more, then wrap with it full.
    for (int i = 0; chan_count < MAX_CH; i++)
      send_command(mcpwm_pkg::CMD_SET, 4'(i), 5'(i + 1), 16'd0, OUT_QUIET);
    send_command(mcpwm_pkg::CMD_SET, 4'd3, 5'd30, 16'd7, OUT_FULL);
    send_command(mcpwm_pkg::CMD_TICK, 4'd0, 5'd0, 16'd0, OUT_MODEL);

    // Random phases, each with its own period and idling style.
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       next_period = 16'd0;
        1:       next_period = 16'd1;
        2:       next_period = 16'hFFFF;
        3:       next_period = 16'($urandom_range(0, 65535));
        default: next_period = 16'($urandom_range(2, 12));
      endcase
      write_period(next_period);
      mode    = $urandom_range(0, 2);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (!hold_done) begin
        // The result side stops for a long stretch while commands keep coming, so the
        // block fills up and has to stall its input.
        tx_calm = 1'b1;
        hold_requests++;
        hold_done = 1'b1;
      end
      burst    = $urandom_range(8, 24);
      pause_at = $urandom_range(0, burst - 1);
      for (int k = 0; k < burst; k++) begin
        // Once per phase the sender pauses until every owed result is back.
        if (k == pause_at) wait_results_clear();
        send_random_command(mode, random_sent);
      end
    end

    wait_results_clear();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (result_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
